>>> src/sms_pkg.sv
`timescale 1ns / 1ps
// Package for the sample mean and standard deviation unit.
// Shared constants, result codes, engine state type and saturation helper.
package sms_pkg;

  localparam int ARITH_W   = 64;
  localparam int ITER_W    = 6;
  localparam int OUT_W     = 24;
  localparam int CNT_OUT_W = 11;
  localparam int ERR_W     = 2;
  localparam int QDEPTH    = 2;

  localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(ARITH_W - 1);
  localparam logic [ITER_W-1:0] ROOT_LAST = ITER_W'(ARITH_W / 2 - 1);

  localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_SINGLE   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN,
    S_MUL_DEN,
    S_MUL_NSQ,
    S_MUL_SS,
    S_DIV_Q,
    S_DIV_F,
    S_ROOT,
    S_DONE
  } back_state_t;

  function automatic logic [OUT_W-1:0] sat24(input logic [ARITH_W-1:0] v);
    logic [OUT_W-1:0] r;
    r = (v > ARITH_W'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
    return r;
  endfunction

endpackage

>>> src/sms_front.sv
`timescale 1ns / 1ps
// Front end: takes samples, squares them, keeps count, sum and sum of squares.
// Hands a finished set to the job queue. Depends on sms_pkg.
module sms_front #(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int CNT_W       = 11,
  parameter int SUM_W       = 27,
  parameter int SQ_W        = 43,
  parameter int LVL_W       = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [15:0]      sample,
  input  logic             last_sample,
  input  logic [LVL_W-1:0] q_level,
  output logic             busy,
  output logic             push,
  output logic [CNT_W-1:0] job_n,
  output logic [SUM_W-1:0] job_sum,
  output logic [SQ_W-1:0]  job_sq,
  output logic             job_ovf
);

  localparam int SQP_W = 2 * SAMPLE_BITS;

  logic                   accept;
  logic [SAMPLE_BITS-1:0] s_in;
  logic [SQP_W-1:0]       s_ext;
  logic                   s1_v;
  logic                   s1_last;
  logic [SAMPLE_BITS-1:0] s1_s;
  logic [SQP_W-1:0]       s1_sq;

  logic [CNT_W-1:0] running_count, running_count_next;
  logic [SUM_W-1:0] running_sum, running_sum_next;
  logic [SQ_W-1:0]  running_square_sum, running_square_sum_next;
  logic             overflow_seen, overflow_seen_next;
  logic [LVL_W:0]   occupancy;

  assign occupancy = {1'b0, q_level} + (LVL_W + 1)'(push);
  assign busy      = occupancy >= (LVL_W + 1)'(sms_pkg::QDEPTH);
  assign accept    = start & ~busy;
  assign s_in      = SAMPLE_BITS'(sample);
  assign s_ext     = SQP_W'(s_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v               <= 1'b0;
      running_count      <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      overflow_seen      <= 1'b0;
    end else begin
      s1_v               <= accept;
      running_count      <= running_count_next;
      running_sum        <= running_sum_next;
      running_square_sum <= running_square_sum_next;
      overflow_seen      <= overflow_seen_next;
    end
    if (accept) begin
      s1_s    <= s_in;
      s1_sq   <= s_ext * s_ext;
      s1_last <= last_sample;
    end
  end

  always_comb begin
    job_n   = running_count;
    job_sum = running_sum;
    job_sq  = running_square_sum;
    job_ovf = overflow_seen;
    push    = 1'b0;
    if (s1_v) begin
      if (running_count == CNT_W'(MAX_SAMPLES)) begin
        job_ovf = 1'b1;
      end else begin
        job_n   = running_count + CNT_W'(1);
        job_sum = running_sum + SUM_W'(s1_s);
        job_sq  = running_square_sum + SQ_W'(s1_sq);
      end
      push = s1_last;
    end
    if (push) begin
      running_count_next      = '0;
      running_sum_next        = '0;
      running_square_sum_next = '0;
      overflow_seen_next      = 1'b0;
    end else begin
      running_count_next      = job_n;
      running_sum_next        = job_sum;
      running_square_sum_next = job_sq;
      overflow_seen_next      = job_ovf;
    end
  end

endmodule

>>> src/sms_queue.sv
`timescale 1ns / 1ps
// Small job queue between the accumulating front end and the compute engine.
// Register storage, one read port. Depends on nothing.
module sms_queue #(
  parameter int WIDTH = 82,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [WIDTH-1:0]         push_data,
  input  logic                     pop,
  output logic [WIDTH-1:0]         pop_data,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      level <= level + LVL_W'(push) - LVL_W'(pop);
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

>>> src/sms_back.sv
`timescale 1ns / 1ps
// Compute engine: shift-add multiplier, restoring divider and digit-by-digit
// square root sharing one set of 64-bit registers. Depends on sms_pkg.
module sms_back #(
  parameter int FRAC_BITS = 8,
  parameter int CNT_W     = 11,
  parameter int SUM_W     = 27,
  parameter int SQ_W      = 43
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                job_valid,
  input  logic [CNT_W-1:0]                    job_n,
  input  logic [SUM_W-1:0]                    job_sum,
  input  logic [SQ_W-1:0]                     job_sq,
  input  logic                                job_ovf,
  output logic                                pop,
  output logic                                done,
  output logic [sms_pkg::OUT_W-1:0]           mean_value,
  output logic [sms_pkg::OUT_W-1:0]           std_deviation,
  output logic [sms_pkg::CNT_OUT_W-1:0]       sample_count,
  output logic [sms_pkg::ERR_W-1:0]           stat_error
);

  localparam int AW    = sms_pkg::ARITH_W;
  localparam int DEN_W = 2 * CNT_W;
  localparam int ITW   = sms_pkg::ITER_W;

  sms_pkg::back_state_t state, state_next;

  logic [CNT_W-1:0]          n_r;
  logic [SUM_W-1:0]          sum_r;
  logic [SQ_W-1:0]           sq_r;
  logic                      ovf_r;
  logic [AW-1:0]             acc, opa, opb, prod, dvd;
  logic [DEN_W-1:0]          rem, dsr;
  logic [sms_pkg::ITER_W-1:0] cnt;

  logic [DEN_W:0]   rem_sh;
  logic             div_ge;
  logic [DEN_W-1:0] rem_new;
  logic [AW-1:0]    dvd_new;
  logic [AW-1:0]    mul_acc;
  logic [AW-1:0]    root_t;
  logic             root_ge;
  logic [AW-1:0]    root_new;
  logic [AW-1:0]    n_ext;

  assign rem_sh   = {rem, dvd[AW-1]};
  assign div_ge   = rem_sh >= {1'b0, dsr};
  assign rem_new  = div_ge ? DEN_W'(rem_sh - {1'b0, dsr}) : rem_sh[DEN_W-1:0];
  assign dvd_new  = {dvd[AW-2:0], div_ge};
  assign mul_acc  = opb[0] ? acc + opa : acc;
  assign root_t   = acc + opa;
  assign root_ge  = dvd >= root_t;
  assign root_new = root_ge ? (acc >> 1) + opa : acc >> 1;
  assign n_ext    = AW'(n_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sms_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    done       = 1'b0;
    case (state)
      sms_pkg::S_IDLE: begin
        if (job_valid) begin
          pop        = 1'b1;
          state_next = sms_pkg::S_MEAN;
        end
      end
      sms_pkg::S_MEAN: begin
        if (cnt == sms_pkg::DIV_LAST) begin
          state_next = (n_r < CNT_W'(2)) ? sms_pkg::S_DONE : sms_pkg::S_MUL_DEN;
        end
      end
      sms_pkg::S_MUL_DEN: begin
        if (opb == '0) state_next = sms_pkg::S_MUL_NSQ;
      end
      sms_pkg::S_MUL_NSQ: begin
        if (opb == '0) state_next = sms_pkg::S_MUL_SS;
      end
      sms_pkg::S_MUL_SS: begin
        if (opb == '0) state_next = sms_pkg::S_DIV_Q;
      end
      sms_pkg::S_DIV_Q: begin
        if (cnt == sms_pkg::DIV_LAST) state_next = sms_pkg::S_DIV_F;
      end
      sms_pkg::S_DIV_F: begin
        if (cnt == sms_pkg::DIV_LAST) state_next = sms_pkg::S_ROOT;
      end
      sms_pkg::S_ROOT: begin
        if (cnt == sms_pkg::ROOT_LAST) state_next = sms_pkg::S_DONE;
      end
      sms_pkg::S_DONE: begin
        done       = 1'b1;
        state_next = sms_pkg::S_IDLE;
      end
      default: state_next = sms_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      sms_pkg::S_IDLE: begin
        if (job_valid) begin
          n_r   <= job_n;
          sum_r <= job_sum;
          sq_r  <= job_sq;
          ovf_r <= job_ovf;
          dvd   <= AW'(job_sum) << FRAC_BITS;
          dsr   <= DEN_W'(job_n);
          rem   <= '0;
          cnt   <= '0;
        end
      end
      sms_pkg::S_MEAN: begin
        dvd <= dvd_new;
        rem <= rem_new;
        cnt <= cnt + ITW'(1);
        if (cnt == sms_pkg::DIV_LAST) begin
          mean_value   <= sms_pkg::sat24(dvd_new);
          sample_count <= n_ext[sms_pkg::CNT_OUT_W-1:0];
          acc          <= '0;
          opa          <= n_ext;
          opb          <= AW'(n_r - CNT_W'(1));
          if (n_r < CNT_W'(2)) begin
            std_deviation <= '0;
            stat_error    <= ovf_r ? sms_pkg::ERR_OVERFLOW : sms_pkg::ERR_SINGLE;
          end else begin
            stat_error    <= ovf_r ? sms_pkg::ERR_OVERFLOW : sms_pkg::ERR_OK;
          end
        end
      end
      sms_pkg::S_MUL_DEN: begin
        if (opb == '0) begin
          dsr <= acc[DEN_W-1:0];
          acc <= '0;
          opa <= AW'(sq_r);
          opb <= n_ext;
        end else begin
          acc <= mul_acc;
          opa <= opa << 1;
          opb <= opb >> 1;
        end
      end
      sms_pkg::S_MUL_NSQ: begin
        if (opb == '0) begin
          prod <= acc;
          acc  <= '0;
          opa  <= AW'(sum_r);
          opb  <= AW'(sum_r);
        end else begin
          acc <= mul_acc;
          opa <= opa << 1;
          opb <= opb >> 1;
        end
      end
      sms_pkg::S_MUL_SS: begin
        if (opb == '0) begin
          dvd <= prod - acc;
          rem <= '0;
          cnt <= '0;
        end else begin
          acc <= mul_acc;
          opa <= opa << 1;
          opb <= opb >> 1;
        end
      end
      sms_pkg::S_DIV_Q: begin
        dvd <= dvd_new;
        rem <= rem_new;
        cnt <= cnt + ITW'(1);
        if (cnt == sms_pkg::DIV_LAST) begin
          prod <= dvd_new;
          dvd  <= AW'(rem_new) << (2 * FRAC_BITS);
          rem  <= '0;
        end
      end
      sms_pkg::S_DIV_F: begin
        dvd <= dvd_new;
        rem <= rem_new;
        cnt <= cnt + ITW'(1);
        if (cnt == sms_pkg::DIV_LAST) begin
          dvd <= (prod << (2 * FRAC_BITS)) + dvd_new;
          acc <= '0;
          opa <= AW'(1) << (AW - 2);
        end
      end
      sms_pkg::S_ROOT: begin
        if (root_ge) dvd <= dvd - root_t;
        acc <= root_new;
        opa <= opa >> 2;
        cnt <= cnt + ITW'(1);
        if (cnt == sms_pkg::ROOT_LAST) begin
          std_deviation <= sms_pkg::sat24(root_new);
        end
      end
      default: ;
    endcase
  end

endmodule

>>> src/sample_mean_and_std_deviation_unit.sv
`timescale 1ns / 1ps
// Top level of the sample mean and standard deviation unit.
// Uses sms_pkg, sms_front, sms_queue and sms_back.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  samples  | start / busy        | sample, last_sample
//  results  | done (1-cycle)      | mean_value, std_deviation, sample_count,
//           |                     | stat_error
//
// Samples are taken one per clock while busy is low. The closing sample of a
// set reaches the two-entry job queue in the cycle after it is taken; busy rises
// while the queue plus that pending job would be full. The engine computes one
// multiplier bit, one quotient bit or one root digit per cycle.
// Reset (rst, synchronous) clears the accumulators, queue and engine; the
// receiver cannot stall, so done lasts one cycle.
module sample_mean_and_std_deviation_unit #(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [15:0]                   sample,
  input  logic                          last_sample,
  output logic                          done,
  output logic [sms_pkg::OUT_W-1:0]     mean_value,
  output logic [sms_pkg::OUT_W-1:0]     std_deviation,
  output logic [sms_pkg::CNT_OUT_W-1:0] sample_count,
  output logic [sms_pkg::ERR_W-1:0]     stat_error
);

  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_RAW = SAMPLE_BITS + CNT_W;
  localparam int SQ_RAW  = 2 * SAMPLE_BITS + CNT_W;
  localparam int SUM_W   = (SUM_RAW > sms_pkg::ARITH_W) ? sms_pkg::ARITH_W : SUM_RAW;
  localparam int SQ_W    = (SQ_RAW > sms_pkg::ARITH_W) ? sms_pkg::ARITH_W : SQ_RAW;
  localparam int JOB_W   = CNT_W + SUM_W + SQ_W + 1;
  localparam int LVL_W   = $clog2(sms_pkg::QDEPTH + 1);

  logic             q_push;
  logic             q_pop;
  logic [LVL_W-1:0] q_level;
  logic [JOB_W-1:0] q_in;
  logic [JOB_W-1:0] q_out;
  logic [CNT_W-1:0] f_n, b_n;
  logic [SUM_W-1:0] f_sum, b_sum;
  logic [SQ_W-1:0]  f_sq, b_sq;
  logic             f_ovf, b_ovf;

  sms_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W),
    .SQ_W       (SQ_W),
    .LVL_W      (LVL_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .sample     (sample),
    .last_sample(last_sample),
    .q_level    (q_level),
    .busy       (busy),
    .push       (q_push),
    .job_n      (f_n),
    .job_sum    (f_sum),
    .job_sq     (f_sq),
    .job_ovf    (f_ovf)
  );

  assign q_in = {f_n, f_sum, f_sq, f_ovf};

  sms_queue #(
    .WIDTH(JOB_W),
    .DEPTH(sms_pkg::QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .pop_data (q_out),
    .level    (q_level)
  );

  assign {b_n, b_sum, b_sq, b_ovf} = q_out;

  sms_back #(
    .FRAC_BITS(FRAC_BITS),
    .CNT_W    (CNT_W),
    .SUM_W    (SUM_W),
    .SQ_W     (SQ_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (q_level != '0),
    .job_n        (b_n),
    .job_sum      (b_sum),
    .job_sq       (b_sq),
    .job_ovf      (b_ovf),
    .pop          (q_pop),
    .done         (done),
    .mean_value   (mean_value),
    .std_deviation(std_deviation),
    .sample_count (sample_count),
    .stat_error   (stat_error)
  );

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_level != LVL_W'(sms_pkg::QDEPTH)))
    else $error("job pushed into a full queue");

  a_single_zero_dev: assert property (@(posedge clk) disable iff (rst)
    (done && stat_error == sms_pkg::ERR_SINGLE) |-> (std_deviation == '0))
    else $error("single-sample set with nonzero deviation");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for sample_mean_and_std_deviation_unit: directed and random sample
// sets go in through start/busy, and each done strobe is checked against a
// running-sum predictor. Depends on sms_pkg and the unit's RTL.
module tb_top;

  localparam int MAX_N        = 1024;
  localparam int FRAC         = 8;
  localparam int RANDOM_ITEMS = 780;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 400;

  typedef enum int {FILL_FULL, FILL_LOW, FILL_HIGH, FILL_FLAT} fill_t;

  typedef struct {
    logic [sms_pkg::OUT_W-1:0]     mean;
    logic [sms_pkg::OUT_W-1:0]     stdev;
    logic [sms_pkg::CNT_OUT_W-1:0] count;
    logic [sms_pkg::ERR_W-1:0]     err;
  } set_stats_t;

  class stats_board;
    longint unsigned count;
    longint unsigned sum;
    longint unsigned square_sum;
    bit overflow;
    set_stats_t pending[$];
    int errors;

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned cand;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
        cand = root | (64'd1 << i);
        if (cand * cand <= v) root = cand;
      end
      return root;
    endfunction

    function logic [sms_pkg::OUT_W-1:0] clip(longint unsigned v);
      return (v > 64'hFF_FFFF) ? sms_pkg::OUT_MAX : v[sms_pkg::OUT_W-1:0];
    endfunction

    function void add_sample(logic [15:0] s, logic last);
      set_stats_t r;
      longint unsigned n, num, den, q, rem, scaled;
      if (count >= MAX_N) begin
        overflow = 1'b1;
      end else begin
        count++;
        sum += 64'(s);
        square_sum += 64'(s) * 64'(s);
      end
      if (!last) return;
      n = count;
      r.mean = clip((sum << FRAC) / n);
      if (n < 2) begin
        r.stdev = '0;
        r.err = sms_pkg::ERR_SINGLE;
      end else begin
        num = n * square_sum - sum * sum;
        den = n * (n - 1);
        q = num / den;
        rem = num % den;
        scaled = (q << (2 * FRAC)) + ((rem << (2 * FRAC)) / den);
        r.stdev = clip(int_sqrt(scaled));
        r.err = sms_pkg::ERR_OK;
      end
      if (overflow) r.err = sms_pkg::ERR_OVERFLOW;
      r.count = n[sms_pkg::CNT_OUT_W-1:0];
      pending.insert(pending.size(), r);
      count = 0;
      sum = 0;
      square_sum = 0;
      overflow = 1'b0;
    endfunction

    function void check_result(set_stats_t got);
      set_stats_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result mean=%0d stdev=%0d count=%0d err=%0d",
                 $time, got.mean, got.stdev, got.count, got.err);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.mean !== want.mean) begin
        $display("%0t: mean_value expected %0d actual %0d", $time, want.mean, got.mean);
        errors++;
      end
      if (got.stdev !== want.stdev) begin
        $display("%0t: std_deviation expected %0d actual %0d", $time, want.stdev, got.stdev);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: sample_count expected %0d actual %0d", $time, want.count, got.count);
        errors++;
      end
      if (got.err !== want.err) begin
        $display("%0t: stat_error expected %0d actual %0d", $time, want.err, got.err);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [15:0]                   sample;
  logic                          last_sample;
  logic                          done;
  logic [sms_pkg::OUT_W-1:0]     mean_value;
  logic [sms_pkg::OUT_W-1:0]     std_deviation;
  logic [sms_pkg::CNT_OUT_W-1:0] sample_count;
  logic [sms_pkg::ERR_W-1:0]     stat_error;

  stats_board board = new();
  set_stats_t seen;
  int cycles = 0;

  sample_mean_and_std_deviation_unit u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .sample(sample),
    .last_sample(last_sample),
    .done(done),
    .mean_value(mean_value),
    .std_deviation(std_deviation),
    .sample_count(sample_count),
    .stat_error(stat_error)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      seen.mean = mean_value;
      seen.stdev = std_deviation;
      seen.count = sample_count;
      seen.err = stat_error;
      board.check_result(seen);
    end
  end

  // start low, inputs carry noise
  task automatic idle_gap(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      sample <= 16'($urandom);
      last_sample <= 1'($urandom);
    end
  endtask

  task automatic send(logic [15:0] s, logic l);
    @(negedge clk);
    start <= 1'b1;
    sample <= s;
    last_sample <= l;
    do @(posedge clk); while (busy);
    board.add_sample(s, l);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 1;
    if (r < 85) return $urandom_range(2, 12);
    return $urandom_range(13, 80);
  endfunction

  function automatic logic [15:0] pick_sample(fill_t fill, logic [15:0] flat);
    case (fill)
      FILL_LOW:  return 16'($urandom_range(0, 15));
      FILL_HIGH: return 16'($urandom_range(16'hFFF0, 16'hFFFF));
      FILL_FLAT: return flat;
      default:   return 16'($urandom);
    endcase
  endfunction

  task automatic send_set(int len, fill_t fill, bit burst);
    logic [15:0] flat;
    flat = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      send(pick_sample(fill, flat), i == len - 1);
      if (!burst) idle_gap(pick_gap());
    end
  endtask

  initial begin
    int sent;
    int len;
    rst = 1'b1;
    start = 1'b0;
    sample = '0;
    last_sample = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single-sample sets, extremes, two-point spread, flat sets
    send(16'h0000, 1'b1);
    send(16'hFFFF, 1'b1);
    send(16'h0000, 1'b0);
    send(16'hFFFF, 1'b1);
    send(16'hFFFF, 1'b0);
    send(16'hFFFF, 1'b0);
    send(16'hFFFF, 1'b1);
    send(16'h0000, 1'b0);
    send(16'h0000, 1'b1);
    send(16'd1, 1'b0);
    send(16'd2, 1'b0);
    send(16'd3, 1'b0);
    send(16'd4, 1'b1);
    send(16'h5555, 1'b0);
    send(16'hAAAA, 1'b0);
    send(16'h8000, 1'b0);
    send(16'h7FFF, 1'b1);
    idle_gap(3);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = pick_len();
      send_set(len, fill_t'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
      sent += len;
    end
    idle_gap(1);

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
